// ----- hw/rtl/dcfe_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dcfe_pkg
// shared types and byte codes of the dimmer channel frame encoder
// ----------------------------------------------------------------------------
package dcfe_pkg;

  localparam logic [7:0] PAD_BYTE   = 8'h7D;
  localparam logic [7:0] SYNC_BYTE  = 8'h7E;
  localparam logic [7:0] ESC_BYTE   = 8'h7F;
  localparam logic [7:0] ADDR_BASE  = 8'h80;
  localparam logic [7:0] ESC_OFFSET = 8'h4E;  // 0x7d..0x7f -> 0x2f..0x31
  localparam logic [6:0] PAD_THRESHOLD = 7'd100;
  localparam logic [6:0] COUNT_TOP     = 7'd127;
  localparam logic [9:0] INDEX_TOP     = 10'd1023;

  // bit positions in the pending-byte mask of the back end
  localparam int unsigned SlotPad  = 4;
  localparam int unsigned SlotSync = 3;
  localparam int unsigned SlotAddr = 2;
  localparam int unsigned SlotEsc  = 1;
  localparam int unsigned SlotData = 0;

  // one classified channel, as queued between front and back
  typedef struct packed {
    logic       pad;
    logic       hdr;
    logic [7:0] addr;
    logic       esc;
    logic [7:0] data;
  } desc_t;

endpackage

`default_nettype wire

// ----- hw/rtl/dcfe_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dcfe_front
// accepts channel bytes, tracks index and byte count, builds descriptors
// ----------------------------------------------------------------------------
module dcfe_front
  import dcfe_pkg::*;
#(
  parameter int MAX_CHANNELS = 512
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [9:0] cfg_wdata,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_channel_value,
  input  wire logic       in_frame_start,
  input  wire logic       q_full,
  output logic            q_push,
  output desc_t           q_desc
);

  localparam logic [10:0] MaxLim = 11'(MAX_CHANNELS);

  logic [9:0]  limit_r;
  logic [9:0]  idx_r;
  logic [9:0]  idx_nxt;
  logic [6:0]  cnt_r;
  logic [6:0]  cnt_nxt;
  logic [9:0]  idx;
  logic [10:0] lim_eff;
  logic        active;
  logic        group;
  logic        pad;
  logic        esc;
  logic        accept;
  logic [6:0]  cnt_base;
  logic [7:0]  cnt_sum;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign idx     = in_frame_start ? 10'd0 : idx_r;
  assign lim_eff = ({1'b0, limit_r} < MaxLim) ? {1'b0, limit_r} : MaxLim;
  assign active  = {1'b0, idx} < lim_eff;
  assign group   = (idx[2:0] == 3'd0);
  assign pad     = group && (cnt_r >= PAD_THRESHOLD);
  assign esc     = (in_channel_value == PAD_BYTE) || (in_channel_value == SYNC_BYTE) ||
                   (in_channel_value == ESC_BYTE);

  // running count after this channel, saturating
  assign cnt_base = pad ? 7'd0 : cnt_r;
  assign cnt_sum  = {1'b0, cnt_base} + (group ? 8'd2 : 8'd0) + (esc ? 8'd2 : 8'd1);

  always_comb begin
    idx_nxt = (idx < INDEX_TOP) ? idx + 10'd1 : idx;
    cnt_nxt = (cnt_sum > {1'b0, COUNT_TOP}) ? COUNT_TOP : cnt_sum[6:0];
  end

  assign q_push      = accept && active;
  assign q_desc.pad  = pad;
  assign q_desc.hdr  = group;
  assign q_desc.addr = ADDR_BASE + {1'b0, idx[9:3]};
  assign q_desc.esc  = esc;
  assign q_desc.data = esc ? in_channel_value - ESC_OFFSET : in_channel_value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= 10'd512;
      idx_r   <= 10'd0;
      cnt_r   <= 7'd0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (accept) begin
        idx_r <= idx_nxt;
        if (active) begin
          cnt_r <= cnt_nxt;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dcfe_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dcfe_fifo
// two-entry descriptor queue between front and back
// ----------------------------------------------------------------------------
module dcfe_fifo #(
  parameter int WIDTH = 19
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wp_r;
  logic             rp_r;
  logic [1:0]       cnt_r;
  logic [1:0]       cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= !wp_r;
      end
      if (pop) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/dcfe_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dcfe_back
// serializes one descriptor into line bytes, one byte per cycle while out_ready holds
// ----------------------------------------------------------------------------
module dcfe_back
  import dcfe_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  q_empty,
  input  wire desc_t q_desc,
  output logic       q_pop,
  output logic       out_valid,
  input  wire logic  out_ready,
  output logic [7:0] out_out_byte,
  output logic       out_run_last
);

  desc_t       desc_r;
  logic [4:0]  mask_r;
  logic [4:0]  mask_nxt;
  logic [4:0]  sel;
  logic [4:0]  mask_left;
  logic [7:0]  byte_sel;
  logic        load_ok;
  logic        emit;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;

  assign load_ok = !out_valid_r || out_ready;
  assign emit    = load_ok && (mask_r != 5'd0);

  // highest pending slot goes first: pad, sync, address, escape, data
  always_comb begin
    sel      = 5'd0;
    byte_sel = desc_r.data;
    if (mask_r[SlotPad]) begin
      sel[SlotPad] = 1'b1;
      byte_sel     = PAD_BYTE;
    end else if (mask_r[SlotSync]) begin
      sel[SlotSync] = 1'b1;
      byte_sel      = SYNC_BYTE;
    end else if (mask_r[SlotAddr]) begin
      sel[SlotAddr] = 1'b1;
      byte_sel      = desc_r.addr;
    end else if (mask_r[SlotEsc]) begin
      sel[SlotEsc] = 1'b1;
      byte_sel     = ESC_BYTE;
    end else begin
      sel[SlotData] = 1'b1;
      byte_sel      = desc_r.data;
    end
  end

  assign mask_left = mask_r & ~sel;
  assign q_pop     = !q_empty && ((mask_r == 5'd0) || (emit && (mask_left == 5'd0)));

  always_comb begin
    mask_nxt = mask_r;
    if (q_pop) begin
      mask_nxt = {q_desc.pad, q_desc.hdr, q_desc.hdr, q_desc.esc, 1'b1};
    end else if (emit) begin
      mask_nxt = mask_left;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      desc_r <= q_desc;
    end
    if (emit) begin
      out_byte_r <= byte_sel;
      out_last_r <= (mask_left == 5'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r <= mask_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_out_byte = out_byte_r;
  assign out_run_last = out_last_r;

endmodule

`default_nettype wire

// ----- hw/rtl/dimmer_channel_frame_encoder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// dimmer_channel_frame_encoder
// turns dimmer channel bytes into the byte stream of a serial dimmer protocol
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  in_*      input      in_valid / in_ready    in_channel_value[7:0], in_frame_start
//  out_*     output     out_valid / out_ready  out_out_byte[7:0], out_run_last
//  cfg_*     input      cfg_we (no wait)       cfg_wdata[9:0] = channel_limit
//
//  each channel gives one to five line bytes, one byte per cycle from the
//  back-end serializer while out_ready holds, so the output byte port sets
//  the sustained input rate
//  dropped channels (at or beyond the limit) are accepted but never queued
//  reset is synchronous, active low; no clearing pass is needed
//  a two-entry descriptor queue lets the front keep accepting while the
//  serializer or the output register is stalled
//
module dimmer_channel_frame_encoder
  import dcfe_pkg::*;
#(
  parameter int MAX_CHANNELS = 512
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // configuration
  input  wire logic       cfg_we,
  input  wire logic [9:0] cfg_wdata,
  // channel input
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_channel_value,
  input  wire logic       in_frame_start,
  // line bytes
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_out_byte,
  output logic            out_run_last
);

  // descriptors flowing front -> queue -> back
  desc_t push_desc;
  desc_t head_desc;
  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_empty;

  // front: index tracking, limit check, pad decision, escape classification
  dcfe_front #(
    .MAX_CHANNELS(MAX_CHANNELS)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_channel_value (in_channel_value),
    .in_frame_start   (in_frame_start),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_desc           (push_desc)
  );

  // decoupling queue
  dcfe_fifo #(
    .WIDTH($bits(desc_t))
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (push_desc),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (head_desc),
    .empty (q_empty)
  );

  // back: byte serializer with registered output
  dcfe_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_empty      (q_empty),
    .q_desc       (head_desc),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_out_byte (out_out_byte),
    .out_run_last (out_run_last)
  );

endmodule

`default_nettype wire

// ----- tb/dimmer_channel_frame_encoder_tb.sv -----
// ----------------------------------------------------------------------------
// dimmer_channel_frame_encoder_tb
// self-checking bench for the dimmer channel frame encoder: channel levels are
// pushed in, every line byte is predicted and compared as it comes out
// ----------------------------------------------------------------------------
module dimmer_channel_frame_encoder_tb;
  import dcfe_pkg::*;

  localparam int MAX_CHANNELS = 512;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 24;       // queue plus serializer plus output reg

  // one predicted line byte
  typedef struct {
    logic [7:0] value;
    logic       last;
  } line_byte_t;

  // predicts the line bytes of each channel and checks them in order
  class line_byte_board;
    line_byte_t predicted_bytes[$];
    logic [9:0] limit;
    logic [9:0] index;
    logic [6:0] since_pad;
    int errors;
    int channels;
    int encoded;
    int bytes_seen;
    int pads;

    function new();
      limit     = 10'd512;
      index     = '0;
      since_pad = '0;
      errors    = 0;
      channels  = 0;
      encoded   = 0;
      bytes_seen = 0;
      pads      = 0;
    endfunction

    function int pending();
      return predicted_bytes.size();
    endfunction

    // saturating add on the bytes-since-pad count
    function void bump_count(int n);
      int sum;
      sum = int'(since_pad) + n;
      since_pad = (sum > int'(COUNT_TOP)) ? COUNT_TOP : 7'(sum);
    endfunction

    // one accepted channel transaction
    function void note_channel(logic [7:0] level, logic start);
      logic [9:0] idx;
      logic [9:0] cap;
      logic [7:0] run_bytes [5];
      line_byte_t entry;
      int n;
      n = 0;
      channels++;
      cap = (limit > 10'(MAX_CHANNELS)) ? 10'(MAX_CHANNELS) : limit;
      if (start) begin
        index = '0;
      end
      idx = index;
      if (index != INDEX_TOP) begin
        index = index + 10'd1;
      end
      if (idx >= cap) begin
        return;
      end
      encoded++;
      // group boundary: optional pad, then sync and group address
      if (idx[2:0] == 3'd0) begin
        if (since_pad >= PAD_THRESHOLD) begin
          run_bytes[n] = PAD_BYTE;
          n++;
          since_pad = '0;
          pads++;
        end
        run_bytes[n] = SYNC_BYTE;
        run_bytes[n + 1] = ADDR_BASE + 8'(idx >> 3);
        n += 2;
        bump_count(2);
      end
      // the three reserved codes go out escaped
      if (level == PAD_BYTE || level == SYNC_BYTE || level == ESC_BYTE) begin
        run_bytes[n] = ESC_BYTE;
        run_bytes[n + 1] = level - ESC_OFFSET;
        n += 2;
        bump_count(2);
      end else begin
        run_bytes[n] = level;
        n++;
        bump_count(1);
      end
      for (int i = 0; i < n; i++) begin
        entry.value = run_bytes[i];
        entry.last  = (i == n - 1);
        predicted_bytes.push_back(entry);
      end
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) begin
        $display("mismatch: %s", what);
      end
    endtask

    // one accepted line byte transaction
    task check_byte(logic [7:0] value, logic last);
      line_byte_t want;
      bytes_seen++;
      if (predicted_bytes.size() == 0) begin
        report($sformatf("unexpected line byte 0x%02h last=%0b", value, last));
      end else begin
        want = predicted_bytes.pop_front();
        if (value !== want.value) begin
          report($sformatf("line byte %0d: got 0x%02h, want 0x%02h",
                           bytes_seen, value, want.value));
        end
        if (last !== want.last) begin
          report($sformatf("line byte %0d (0x%02h): run_last %0b, want %0b",
                           bytes_seen, value, last, want.last));
        end
      end
    endtask
  endclass

  // all inputs known from time zero
  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [9:0] cfg_wdata = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_channel_value = '0;
  logic       in_frame_start = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_out_byte;
  logic       out_run_last;

  line_byte_board board = new();
  int idle_pct  = 0;   // chance per cycle that the sender holds back
  int stall_pct = 0;   // chance per cycle that the receiver stalls
  int cycles    = 0;

  dimmer_channel_frame_encoder #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_channel_value (in_channel_value),
    .in_frame_start   (in_frame_start),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_out_byte     (out_out_byte),
    .out_run_last     (out_run_last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d line bytes still owed",
               cycles, board.pending());
      $display("dimmer_channel_frame_encoder_tb: done, errors");
      $finish;
    end
  end

  // receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // line byte monitor; values read here are the ones at the edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      board.check_byte(out_out_byte, out_run_last);
    end
  end

  task automatic set_pacing(input int sender_idle, input int receiver_stall);
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
  endtask

  // one channel transaction; valid holds with a steady payload until taken
  task automatic send_channel(input logic [7:0] level, input logic start);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_channel_value <= level;
    in_frame_start   <= start;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    board.note_channel(level, start);
  endtask

  // wait until every predicted byte is out, then let the pipe go quiet
  task automatic drain_line();
    in_valid <= 1'b0;
    while (board.pending() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // limit register writes only happen on an idle block
  task automatic write_limit(input logic [9:0] value);
    drain_line();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.limit = value;
  endtask

  // a quarter of the levels land on the escaped codes
  function automatic logic [7:0] pick_level();
    if ($urandom_range(3) == 0) begin
      return 8'(int'(PAD_BYTE) + $urandom_range(2));
    end
    return 8'($urandom_range(255));
  endfunction

  // well-formed frames of random length and content; now and then a frame
  // carries on without a start mark or a stray start cuts one short
  task automatic run_frames(input int item_goal, input int max_len);
    int sent;
    int len;
    bit carry_on;
    sent = 0;
    while (sent < item_goal) begin
      len = $urandom_range(max_len, 1);
      carry_on = ($urandom_range(9) == 0);
      for (int i = 0; i < len && sent < item_goal; i++) begin
        send_channel(pick_level(), (i == 0 && !carry_on) || ($urandom_range(39) == 0));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset limit, byte extremes, the three escapes, a second
    // group address and a frame restart in the middle of a group
    set_pacing(0, 0);
    send_channel(8'h00, 1'b1);
    send_channel(8'hFF, 1'b0);
    send_channel(PAD_BYTE, 1'b0);
    send_channel(SYNC_BYTE, 1'b0);
    send_channel(ESC_BYTE, 1'b0);
    send_channel(8'h7C, 1'b0);
    send_channel(ADDR_BASE, 1'b0);
    send_channel(8'h01, 1'b0);
    send_channel(8'h55, 1'b0);
    send_channel(ESC_BYTE, 1'b0);
    send_channel(8'hAA, 1'b1);
    send_channel(SYNC_BYTE, 1'b0);
    send_channel(8'h2F, 1'b0);

    // limit of zero: everything is dropped, nothing may come out
    write_limit(10'd0);
    set_pacing(70, 0);
    for (int i = 0; i < 24; i++) begin
      send_channel(pick_level(), 1'($urandom_range(1)));
    end

    // full limit, free running; frames long enough to bring in pad bytes
    write_limit(10'd512);
    set_pacing(0, 0);
    run_frames(70, 120);

    // limit off a group boundary, bursty sender
    write_limit(10'd13);
    set_pacing(70, 0);
    run_frames(40, 40);

    // random limit, slow receiver
    write_limit(10'($urandom_range(512, 1)));
    set_pacing(0, 70);
    run_frames(40, 90);

    // one channel per frame
    write_limit(10'd1);
    set_pacing(26, 26);
    run_frames(20, 6);

    // exactly one group per frame
    write_limit(10'd8);
    set_pacing(26, 26);
    run_frames(30, 20);

    // register above the channel count: the channel count caps the frame
    write_limit(10'd1023);
    set_pacing(26, 26);
    run_frames(25, 20);

    drain_line();

    $display("%0d channel transactions, %0d encoded, %0d line bytes checked, %0d pads",
             board.channels, board.encoded, board.bytes_seen, board.pads);
    $display("limits 0, 1, 8, 13, 512, 1023 and one random, under four pacing mixes");
    if (board.errors == 0) begin
      $display("dimmer_channel_frame_encoder_tb: done, clean");
    end else begin
      $display("%0d mismatches", board.errors);
      $display("dimmer_channel_frame_encoder_tb: done, errors");
    end
    $finish;
  end

endmodule
